// ----- src/ctbr_pkg.sv -----
// Shared types, command codes and helpers for the code-tracking byte RAM.
package ctbr_pkg;

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_TRACK   = 2'd2;
  localparam logic [1:0] CMD_UNTRACK = 2'd3;

  localparam logic [31:0] GEN_RESET = 32'd1;

  typedef struct packed {
    logic        tracked;
    logic [31:0] gen;
  } page_entry_t;

  // Per-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic calc;
    logic fetch_a;
    logic fetch_b;
    logic fetch_c;
    logic upd_a;
    logic upd_b;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

  // Generation counters never show zero: a wrap lands on one.
  function automatic logic [31:0] gen_bump(input logic [31:0] gen);
    logic [31:0] sum;
    sum = gen + 32'd1;
    return (sum == 32'd0) ? GEN_RESET : sum;
  endfunction

endpackage

// ----- src/code_tracking_byte_ram.sv -----
// Byte-addressed RAM with little-endian accesses of 1 to 8 bytes and per-page code tracking.
// After reset the block sweeps max(ceil(RAM_BYTES/8), PAGE_COUNT) addresses of its memories
// and accepts no transaction meanwhile. Each accepted transaction then steps through the
// calc, fetch (A, B, C), update (A, B) and done states; in the done state its result is
// loaded into the output register, and in_ready rises in the same cycle. The data RAM
// is 64 bits wide with one read and one write port, so an access that may straddle two words
// takes two reads and two read-modify-write steps, and the two page entries (first and last
// page touched) are read and updated one after the other through the page RAM's single
// ports. A finished result sits in the output register while the next transaction is
// accepted; the next transaction cannot finish until that result has been taken.
module code_tracking_byte_ram #(
  parameter int RAM_BYTES  = 2097152,
  parameter int PAGE_BYTES = 4096,
  parameter int PAGE_COUNT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [1:0]  size_code,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [63:0] read_data,
  output logic [31:0] page_generation
);

  import ctbr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ctbr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  ctbr_datapath #(
    .RAM_BYTES (RAM_BYTES),
    .PAGE_BYTES(PAGE_BYTES),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .command        (command),
    .address        (address),
    .size_code      (size_code),
    .write_data     (write_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .ok             (ok),
    .read_data      (read_data),
    .page_generation(page_generation)
  );

endmodule

// ----- src/ctbr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ctbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ctbr_datapath.sv -----
// Datapath: input registers, page index multipliers, data and page RAMs, result register.
module ctbr_datapath #(
  parameter int RAM_BYTES  = 2097152,
  parameter int PAGE_BYTES = 4096,
  parameter int PAGE_COUNT = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctbr_pkg::dp_cmd_t    cmd,
  output ctbr_pkg::dp_status_t status,
  input  logic [1:0]           command,
  input  logic [31:0]          address,
  input  logic [1:0]           size_code,
  input  logic [63:0]          write_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 ok,
  output logic [63:0]          read_data,
  output logic [31:0]          page_generation
);

  import ctbr_pkg::*;

  localparam int ADDR_W    = $clog2(RAM_BYTES);
  localparam int WORDS     = (RAM_BYTES + 7) / 8;
  localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PAGE_AW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PAGE_L    = $clog2(PAGE_BYTES);
  // Page index = (byte address * RECIP) >> RECIP_SH, exact for every address below RAM_BYTES.
  localparam int RECIP_SH  = ADDR_W + PAGE_L;
  localparam int RECIP_W   = ADDR_W + 2;
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int PROD_W    = ADDR_W + RECIP_W;
  localparam int CLEAR_LEN = (WORDS > PAGE_COUNT) ? WORDS : PAGE_COUNT;
  localparam int CLR_W     = $clog2(CLEAR_LEN);

  logic [1:0]        cmd_r;
  logic [31:0]       addr_r;
  logic [1:0]        size_r;
  logic [63:0]       wdata_r;
  logic [PROD_W-1:0] prod0;
  logic [PROD_W-1:0] prod1;
  logic [63:0]       lo_word;
  logic [63:0]       hi_word;
  page_entry_t       entry0;
  page_entry_t       entry1;
  logic [CLR_W-1:0]  clr_cnt;

  logic [3:0]        len;
  logic [32:0]       end_sum;
  logic              in_range;
  logic              addr_ok;
  logic [ADDR_W-1:0] last_addr;
  logic [2:0]        byte_off;
  logic [WORD_AW-1:0] word0;
  logic [WORD_AW-1:0] word1;
  logic              spans;
  logic [ADDR_W-1:0] pq0;
  logic [ADDR_W-1:0] pq1;
  logic              pv0;
  logic              pv1;
  logic              is_read;
  logic              is_write;
  logic              is_mark;
  logic              do_write;
  logic              bump0;
  logic              bump1;
  logic              mark;
  logic [8:0]        base_wide;
  logic [7:0]        base_mask;
  logic [15:0]       lane_mask;
  logic [127:0]      bit_mask;
  logic [63:0]       len_mask;
  logic [127:0]      window;
  logic [127:0]      data_shift;
  logic [127:0]      merged;
  logic [127:0]      rd_shift;
  logic [63:0]       rd_val;

  logic               dwe;
  logic [WORD_AW-1:0] dwaddr;
  logic [63:0]        dwdata;
  logic [WORD_AW-1:0] draddr;
  logic [63:0]        drdata;
  logic               pwe;
  logic [PAGE_AW-1:0] pwaddr;
  page_entry_t        pwdata;
  logic [PAGE_AW-1:0] praddr;
  logic [$bits(page_entry_t)-1:0] prdata;

  assign len       = 4'd1 << size_r;
  assign end_sum   = {1'b0, addr_r} + 33'(len);
  assign in_range  = end_sum <= 33'(RAM_BYTES);
  assign addr_ok   = addr_r < 32'(RAM_BYTES);
  assign last_addr = ADDR_W'(end_sum - 33'd1);
  assign byte_off  = addr_r[2:0];
  assign word0     = WORD_AW'(addr_r >> 3);
  assign word1     = word0 + WORD_AW'(1);
  assign spans     = ({1'b0, byte_off} + len) > 4'd8;

  assign pq0 = ADDR_W'(prod0 >> RECIP_SH);
  assign pq1 = ADDR_W'(prod1 >> RECIP_SH);
  assign pv0 = addr_ok && (32'(pq0) < 32'(PAGE_COUNT));
  assign pv1 = 32'(pq1) < 32'(PAGE_COUNT);

  assign is_read  = cmd_r == CMD_READ;
  assign is_write = cmd_r == CMD_WRITE;
  assign is_mark  = (cmd_r == CMD_TRACK) || (cmd_r == CMD_UNTRACK);
  assign do_write = is_write && in_range;
  assign bump0    = do_write && pv0 && entry0.tracked;
  // The last page only counts when it is a different page from the first.
  assign bump1    = do_write && pv1 && (pq1 != pq0) && entry1.tracked;
  assign mark     = is_mark && pv0;

  assign base_wide = (9'd1 << len) - 9'd1;
  assign base_mask = base_wide[7:0];
  assign lane_mask = 16'(base_mask) << byte_off;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      bit_mask[i*8 +: 8] = {8{lane_mask[i]}};
    end
    for (int i = 0; i < 8; i++) begin
      len_mask[i*8 +: 8] = {8{base_mask[i]}};
    end
  end

  assign window     = {hi_word, lo_word};
  assign data_shift = {64'd0, wdata_r} << {byte_off, 3'b000};
  assign merged     = (window & ~bit_mask) | (data_shift & bit_mask);
  assign rd_shift   = window >> {byte_off, 3'b000};
  assign rd_val     = rd_shift[63:0] & len_mask;

  // Data RAM: 64-bit words; an unaligned access covers at most two words.
  assign draddr = cmd.fetch_a ? word1 : word0;

  always_comb begin
    dwe    = 1'b0;
    dwaddr = word0;
    dwdata = merged[63:0];
    priority if (cmd.clear) begin
      dwe    = 32'(clr_cnt) < 32'(WORDS);
      dwaddr = WORD_AW'(clr_cnt);
      dwdata = 64'd0;
    end else if (cmd.upd_a) begin
      dwe = do_write;
    end else if (cmd.upd_b) begin
      dwe    = do_write && spans;
      dwaddr = word1;
      dwdata = merged[127:64];
    end
  end

  assign praddr = cmd.fetch_b ? PAGE_AW'(pq1) : PAGE_AW'(pq0);

  always_comb begin
    pwe    = 1'b0;
    pwaddr = PAGE_AW'(pq0);
    pwdata = '{tracked: 1'b1, gen: gen_bump(entry0.gen)};
    priority if (cmd.clear) begin
      pwe    = 32'(clr_cnt) < 32'(PAGE_COUNT);
      pwaddr = PAGE_AW'(clr_cnt);
      pwdata = '{tracked: 1'b0, gen: GEN_RESET};
    end else if (cmd.upd_a) begin
      pwe = bump0 || mark;
      if (mark) begin
        pwdata = '{tracked: (cmd_r == CMD_TRACK), gen: entry0.gen};
      end
    end else if (cmd.upd_b) begin
      pwe    = bump1;
      pwaddr = PAGE_AW'(pq1);
      pwdata = '{tracked: 1'b1, gen: gen_bump(entry1.gen)};
    end
  end

  ctbr_ram #(
    .WIDTH(64),
    .DEPTH(WORDS)
  ) u_data_ram (
    .clk  (clk),
    .we   (dwe),
    .waddr(dwaddr),
    .wdata(dwdata),
    .raddr(draddr),
    .rdata(drdata)
  );

  ctbr_ram #(
    .WIDTH($bits(page_entry_t)),
    .DEPTH(PAGE_COUNT)
  ) u_page_ram (
    .clk  (clk),
    .we   (pwe),
    .waddr(pwaddr),
    .wdata(pwdata),
    .raddr(praddr),
    .rdata(prdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= command;
      addr_r  <= address;
      size_r  <= size_code;
      wdata_r <= write_data;
    end
    if (cmd.calc) begin
      prod0 <= PROD_W'(addr_r[ADDR_W-1:0]) * PROD_W'(RECIP);
      prod1 <= PROD_W'(last_addr) * PROD_W'(RECIP);
    end
    if (cmd.fetch_a) begin
      lo_word <= drdata;
    end
    if (cmd.fetch_b) begin
      hi_word <= drdata;
      entry0  <= prdata;
    end
    if (cmd.fetch_c) begin
      entry1 <= prdata;
    end
    if (cmd.load) begin
      ok              <= (is_read || is_write) ? in_range : pv0;
      read_data       <= (is_read && in_range) ? rd_val : 64'd0;
      page_generation <= !pv0 ? 32'd0 : (bump0 ? gen_bump(entry0.gen) : entry0.gen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.clear_last = clr_cnt == CLR_W'(CLEAR_LEN - 1);
  assign status.out_free   = !out_valid || out_ready;

endmodule

// ----- src/ctbr_ctrl.sv -----
// Controller: sequences the clearing pass and the fixed steps of each transaction.
module ctbr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ctbr_pkg::dp_status_t status,
  output ctbr_pkg::dp_cmd_t    cmd
);

  import ctbr_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_FETCH_C,
    ST_UPD_A,
    ST_UPD_B,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.capture = in_valid && in_ready;
        if (in_valid && in_ready) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_FETCH_A;
      end
      ST_FETCH_A: begin
        cmd.fetch_a = 1'b1;
        state_next  = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        cmd.fetch_b = 1'b1;
        state_next  = ST_FETCH_C;
      end
      ST_FETCH_C: begin
        cmd.fetch_c = 1'b1;
        state_next  = ST_UPD_A;
      end
      ST_UPD_A: begin
        cmd.upd_a  = 1'b1;
        state_next = ST_UPD_B;
      end
      ST_UPD_B: begin
        cmd.upd_b  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold the finished result until the output register can take it.
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= state_next == ST_IDLE;
    end
  end

endmodule

// ----- src/ctbr_checker.sv -----
// Port-level checks for the code-tracking byte RAM, bound to the top level.
module ctbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [63:0] read_data,
  input logic [31:0] page_generation
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(read_data)
      && $stable(page_generation))
    else $error("result changed while stalled");

  // A refused transaction never returns read data.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> read_data == 64'd0)
    else $error("refused transaction returned data");

  // Transactions are worked one at a time, so ready drops after each acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  // Reset leaves the block neither ready nor presenting a result.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("handshake active right after reset");

endmodule

bind code_tracking_byte_ram ctbr_checker u_ctbr_checker (.*);

// ----- tb/code_tracking_byte_ram_tb.sv -----
// Self-checking testbench for the code-tracking byte RAM.
module code_tracking_byte_ram_tb;
  import ctbr_pkg::*;

  localparam longint unsigned RAM_SIZE  = 2097152;
  localparam longint unsigned PAGE_SIZE = 4096;
  localparam int              PAGES     = 512;
  localparam int              HOLD_OFF  = 300;

  typedef struct packed {
    logic        ok;
    logic [63:0] rdata;
    logic [31:0] gen;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_READ;
  logic [31:0] address = '0;
  logic [1:0]  size_code = '0;
  logic [63:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [63:0] read_data;
  logic [31:0] page_generation;

  // Shadow state of the block.
  logic [7:0]  mem_image [int unsigned];
  logic [31:0] gen_table [PAGES];
  bit          tracked_table [PAGES];

  response_t   pending_responses [$];
  int          accepted_count = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          cmd_count [4] = '{0, 0, 0, 0};
  int          refused_count = 0;
  logic [31:0] top_generation = '0;
  int          hold_off_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  code_tracking_byte_ram #(
    .RAM_BYTES (int'(RAM_SIZE)),
    .PAGE_BYTES(int'(PAGE_SIZE)),
    .PAGE_COUNT(PAGES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .address        (address),
    .size_code      (size_code),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .read_data      (read_data),
    .page_generation(page_generation)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Applies one transaction to the shadow state and returns the response it must produce.
  function automatic response_t predict_response(input logic [1:0] cmd, input logic [31:0] addr,
                                                 input logic [1:0] size,
                                                 input logic [63:0] data);
    response_t       r;
    longint unsigned a64;
    longint unsigned span;
    longint unsigned pg;
    int              page_idx;
    int unsigned     k;
    r = '0;
    a64 = addr;
    span = 64'd1 << size;
    page_idx = (a64 < RAM_SIZE && a64 / PAGE_SIZE < PAGES) ? int'(a64 / PAGE_SIZE) : -1;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (a64 + span <= RAM_SIZE) begin
        r.ok = 1'b1;
        for (int i = 0; i < int'(span); i++) begin
          k = int'(a64) + i;
          if (cmd == CMD_READ)
            r.rdata[8*i +: 8] = mem_image.exists(k) ? mem_image[k] : 8'h00;
          else
            mem_image[k] = data[8*i +: 8];
        end
        if (cmd == CMD_WRITE) begin
          for (pg = a64 / PAGE_SIZE; pg <= (a64 + span - 1) / PAGE_SIZE && pg < PAGES; pg++) begin
            if (tracked_table[pg])
              gen_table[pg] = (gen_table[pg] == 32'hFFFF_FFFF) ? 32'd1 : gen_table[pg] + 32'd1;
          end
        end
      end
    end else if (page_idx >= 0) begin
      tracked_table[page_idx] = (cmd == CMD_TRACK);
      r.ok = 1'b1;
    end
    r.gen = (page_idx >= 0) ? gen_table[page_idx] : 32'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Predicts on every accepted request and checks every accepted response in order.
  always @(posedge clk) begin
    response_t want;
    if (!rst && in_valid && in_ready) begin
      pending_responses.push_back(predict_response(command, address, size_code, write_data));
      accepted_count++;
      cmd_count[command]++;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = pending_responses.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("ok of response %0d: got %b, expected %b",
                                    results_seen, ok, want.ok));
        if (read_data !== want.rdata)
          report_mismatch($sformatf("read_data of response %0d: got %h, expected %h",
                                    results_seen, read_data, want.rdata));
        if (page_generation !== want.gen)
          report_mismatch($sformatf("page_generation of response %0d: got %0d, expected %0d",
                                    results_seen, page_generation, want.gen));
        if (!want.ok)
          refused_count++;
        if (want.gen > top_generation)
          top_generation = want.gen;
      end
      results_seen++;
    end
  end

  // Response side: random pauses, plus a long hold-off when one is requested.
  initial begin : receiver
    int pause;
    int seen;
    forever begin
      pause = rx_gaps_on ? $urandom_range(0, 17) : 0;
      pause += hold_off_cycles;
      hold_off_cycles = 0;
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      seen = results_seen;
      do @(negedge clk); while (results_seen == seen);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] addr,
                           input logic [1:0] size, input logic [63:0] data);
    int pause;
    int seen;
    pause = tx_gaps_on ? $urandom_range(0, 17) : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    command    <= cmd;
    address    <= addr;
    size_code  <= size;
    write_data <= data;
    in_valid   <= 1'b1;
    seen = accepted_count;
    do @(negedge clk); while (accepted_count == seen);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_responses.size() != 0)
      @(negedge clk);
  endtask

  // Addresses mostly cluster around a few page boundaries and the end of the RAM so reads find earlier writes.
  function automatic logic [31:0] pick_address;
    int unsigned hot_pages [6] = '{0, 1, 2, 255, 256, 511};
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return 32'(hot_pages[$urandom_range(0, 5)] * PAGE_SIZE - 8 + $urandom_range(0, 19));
    else if (sel < 75)
      return 32'(RAM_SIZE - 16 + $urandom_range(0, 23));
    else if (sel < 90)
      return $urandom_range(0, 32'(RAM_SIZE - 1));
    else
      return $urandom;
  endfunction

  task automatic send_random_item;
    int unsigned sel;
    logic [1:0]  cmd;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      cmd = CMD_READ;
    else if (sel < 80)
      cmd = CMD_WRITE;
    else if (sel < 92)
      cmd = CMD_TRACK;
    else
      cmd = CMD_UNTRACK;
    send_item(cmd, pick_address(), 2'($urandom_range(0, 3)), {$urandom, $urandom});
  endtask

  task automatic test_reset_state;
    send_item(CMD_READ, 32'd0, 2'd3, 64'd0);
    send_item(CMD_READ, 32'(RAM_SIZE - 8), 2'd3, 64'd0);
    send_item(CMD_READ, 32'h0001_2345, 2'd2, 64'd0);
    drain();
  endtask

  task automatic test_bounds;
    send_item(CMD_WRITE, 32'(RAM_SIZE - 8), 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_READ, 32'(RAM_SIZE - 8), 2'd3, 64'd0);
    send_item(CMD_WRITE, 32'(RAM_SIZE - 1), 2'd0, 64'h0000_0000_0000_00A5);
    send_item(CMD_WRITE, 32'(RAM_SIZE - 1), 2'd1, 64'h1234);
    send_item(CMD_READ, 32'(RAM_SIZE - 7), 2'd3, 64'd0);
    // The end address overflows 32 bits here; the access must still be refused.
    send_item(CMD_READ, 32'hFFFF_FFFF, 2'd3, 64'd0);
    send_item(CMD_WRITE, 32'hFFFF_FFFC, 2'd2, 64'hDEAD_BEEF);
    send_item(CMD_TRACK, 32'(RAM_SIZE), 2'd0, 64'd0);
    send_item(CMD_UNTRACK, 32'hFFFF_FFFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_tracking;
    send_item(CMD_TRACK, 32'(PAGE_SIZE + 77), 2'd3, {$urandom, $urandom});
    send_item(CMD_WRITE, 32'(PAGE_SIZE), 2'd0, 64'h5A);
    // Straddles an untracked page and a tracked one.
    send_item(CMD_WRITE, 32'(PAGE_SIZE - 1), 2'd3, 64'h8877_6655_4433_2211);
    send_item(CMD_TRACK, 32'd0, 2'd0, 64'd0);
    send_item(CMD_WRITE, 32'(PAGE_SIZE - 4), 2'd3, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_READ, 32'(PAGE_SIZE - 2), 2'd3, 64'd0);
    send_item(CMD_UNTRACK, 32'(PAGE_SIZE + 4), 2'd1, 64'd0);
    send_item(CMD_WRITE, 32'(PAGE_SIZE + 4), 2'd2, 64'h0);
    drain();
  endtask

  // The output is held off while requests keep coming, so the block must stall its input.
  task automatic test_backpressure;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_off_cycles = HOLD_OFF;
    repeat (24) send_random_item();
    drain();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_random;
    for (int chunk = 0; chunk < 27; chunk++) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (50) send_random_item();
    end
    drain();
  endtask

  initial begin
    for (int p = 0; p < PAGES; p++) begin
      gen_table[p] = 32'd1;
      tracked_table[p] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_bounds();
    test_tracking();
    test_backpressure();
    test_random();
    repeat (20) @(negedge clk);
    $display("Ran %0d reads, %0d writes, %0d track and %0d untrack commands; %0d were refused.",
             cmd_count[CMD_READ], cmd_count[CMD_WRITE], cmd_count[CMD_TRACK],
             cmd_count[CMD_UNTRACK], refused_count);
    $display("Highest page generation reported: %0d; output held off once for %0d cycles.",
             top_generation, HOLD_OFF);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
